>>> design/per_site_character_count_matrix_unit_macros.svh
// Assertion macros shared by the per-site character count matrix unit.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef PER_SITE_CHARACTER_COUNT_MATRIX_UNIT_MACROS_SVH
`define PER_SITE_CHARACTER_COUNT_MATRIX_UNIT_MACROS_SVH

// Checked only while the block is out of reset.
`define PSCM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked at every clock edge, reset included.
`define PSCM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

>>> design/pscm_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the per-site character count matrix unit.
// Standalone; imported by the controller, the datapath and the top level.
package pscm_pkg;

   localparam int PSCM_MAX_SITES   = 1024;
   localparam int PSCM_MAX_CHARS   = 8;
   localparam int PSCM_COUNT_WIDTH = 32;

   localparam int KIND_W       = 2;
   localparam int CHAR_W       = 8;
   localparam int SITE_FIELD_W = 10;
   localparam int SET_INDEX_W  = 4;
   localparam int STATUS_W     = 3;
   localparam int RSP_COUNT_W  = 32;
   localparam int RSP_SEQ_W    = 32;
   localparam int CHAR_SET_W   = 64;
   localparam int SET_SIZE_W   = 4;
   localparam int SITE_COUNT_W = 11;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 64;
   localparam int SET_SLOTS    = CHAR_SET_W / CHAR_W;

   localparam logic [SET_INDEX_W-1:0] NO_INDEX = '1;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD        = 2'd0,
      KIND_READ_INDEX = 2'd1,
      KIND_READ_CHAR  = 2'd2,
      KIND_NOP        = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_ACCEPTED     = 3'd0,
      STS_COMMITTED    = 3'd1,
      STS_LEN_MISMATCH = 3'd2,
      STS_SATURATED    = 3'd3,
      STS_BAD_SITE     = 3'd4,
      STS_BAD_CHAR     = 3'd5
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHAR_SET   = 2'd0,
      CSR_SET_SIZE   = 2'd1,
      CSR_SITE_COUNT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic [CHAR_W-1:0]       character;
      logic                    is_last;
      logic [SITE_FIELD_W-1:0] site;
      logic [SET_INDEX_W-1:0]  set_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [RSP_COUNT_W-1:0] count;
      logic [RSP_SEQ_W-1:0]   sequences_added;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic clear_en;
      logic exec_en;
      logic exec_respond;
      logic walk_issue;
      logic finish;
      logic read_respond;
   } ctl_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic clear_last;
      logic exec_read;
      logic exec_walk;
      logic walk_last;
      logic pipe_empty;
   } dp_status_type;

   function automatic logic [CHAR_W-1:0] upper_char(input logic [CHAR_W-1:0] c);
      if (c >= 8'h61 && c <= 8'h7a) begin
         return c - 8'h20;
      end
      return c;
   endfunction

   // Lowest set index whose character equals c without regard to case.
   function automatic logic [SET_INDEX_W-1:0] set_lookup(
      input logic [CHAR_SET_W-1:0] set_chars,
      input logic [SET_SIZE_W-1:0] n,
      input logic [CHAR_W-1:0]     c
   );
      logic [SET_INDEX_W-1:0] idx;
      logic [CHAR_W-1:0]      uc;
      idx = NO_INDEX;
      uc  = upper_char(c);
      for (int i = SET_SLOTS - 1; i >= 0; i--) begin
         if (SET_SIZE_W'(i) < n && upper_char(set_chars[CHAR_W*i +: CHAR_W]) == uc) begin
            idx = SET_INDEX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

>>> design/pscm_ctrl.sv
`timescale 1ns / 1ps
// Controller of the count matrix unit: sequences clearing, execution, the commit walk and reads.
// Depends on pscm_pkg and the shared assertion macro header.
`include "per_site_character_count_matrix_unit_macros.svh"

module pscm_ctrl
   import pscm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  dp_status_type sts,
   output ctl_cmd_type   cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_WALK,
      S_DRAIN,
      S_RDATA
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   always_comb begin
      state_in = state_ff;
      busy_in  = busy_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
               busy_in  = 1'b0;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
               busy_in     = 1'b1;
            end
         end
         S_EXEC: begin
            cmd.exec_en = 1'b1;
            if (sts.exec_read) begin
               state_in = S_RDATA;
            end else if (sts.exec_walk) begin
               state_in = S_WALK;
            end else begin
               cmd.exec_respond = 1'b1;
               state_in         = S_IDLE;
               busy_in          = 1'b0;
            end
         end
         S_WALK: begin
            cmd.walk_issue = 1'b1;
            if (sts.walk_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // The last increment has been written once the pipeline is empty.
            if (sts.pipe_empty) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
               busy_in    = 1'b0;
            end
         end
         S_RDATA: begin
            cmd.read_respond = 1'b1;
            state_in         = S_IDLE;
            busy_in          = 1'b0;
         end
         default: begin
            state_in = S_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

   `PSCM_ASSERT_ALWAYS(a_reset_clears, reset |=> (state_ff == S_CLEAR && busy_ff), "reset did not start the clearing pass")
   `PSCM_ASSERT(a_accept_exec, (start && !busy_ff) |=> (state_ff == S_EXEC), "accepted transfer did not reach execution")
   `PSCM_ASSERT(a_idle_matches_busy, (state_ff == S_IDLE) == !busy_ff, "busy disagrees with the controller state")

endmodule

>>> design/pscm_datapath.sv
`timescale 1ns / 1ps
// Datapath of the count matrix unit: registers, staging memory, count memory, commit pipeline.
// Depends on pscm_pkg and the shared assertion macro header.
`include "per_site_character_count_matrix_unit_macros.svh"

module pscm_datapath
   import pscm_pkg::*;
#(
   parameter int MAX_SITES   = PSCM_MAX_SITES,
   parameter int MAX_CHARS   = PSCM_MAX_CHARS,
   parameter int COUNT_WIDTH = PSCM_COUNT_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctl_cmd_type            cmd,
   output dp_status_type          sts,
   input  req_type                req_data,
   output logic                   rsp_strobe,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int MEM_DEPTH   = MAX_SITES * MAX_CHARS;
   localparam int ADDR_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int SITE_ADDR_W = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
   localparam int LEN_W       = $clog2(MAX_SITES + 2);

   // Configuration registers.
   logic [CHAR_SET_W-1:0]   char_set_ff;
   logic [SET_SIZE_W-1:0]   set_size_ff;
   logic [SITE_COUNT_W-1:0] site_count_ff;

   logic [SET_SIZE_W-1:0]   eff_size;
   logic [SITE_COUNT_W-1:0] eff_sites;

   req_type                 req_ff;
   logic [LEN_W-1:0]        staged_len_ff;
   logic [LEN_W-1:0]        len_inc;
   logic [COUNT_WIDTH-1:0]  total_ff;
   logic                    saturated;

   logic [SET_INDEX_W-1:0]  char_ix;
   logic [SET_INDEX_W-1:0]  q_ix;
   logic [ADDR_W-1:0]       q_addr;
   status_type              q_status;
   status_type              q_status_ff;
   status_type              exec_status;
   logic                    exec_walk;
   logic                    exec_read;
   logic                    stage_write;

   logic [SET_INDEX_W-1:0]  staged_mem [MAX_SITES];
   logic [COUNT_WIDTH-1:0]  count_mem [MEM_DEPTH];

   logic [ADDR_W-1:0]       clear_ptr_ff;
   logic [SITE_ADDR_W-1:0]  walk_ptr_ff;
   logic [SITE_ADDR_W-1:0]  s1_site_ff;
   logic [SET_INDEX_W-1:0]  s1_ix_ff;
   logic                    p1_ff;
   logic                    p2_ff;
   logic [ADDR_W-1:0]       s1_addr;
   logic                    s1_hit;
   logic [ADDR_W-1:0]       s2_addr_ff;
   logic [COUNT_WIDTH-1:0]  rdata_ff;

   logic [ADDR_W-1:0]       rd_addr;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr;
   logic [COUNT_WIDTH-1:0]  mem_wdata;

   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;

   assign eff_size  = (32'(set_size_ff) > 32'(MAX_CHARS)) ? SET_SIZE_W'(MAX_CHARS) : set_size_ff;
   assign eff_sites = (32'(site_count_ff) > 32'(MAX_SITES)) ? SITE_COUNT_W'(MAX_SITES)
                                                            : site_count_ff;
   assign saturated = &total_ff;
   assign char_ix   = set_lookup(char_set_ff, eff_size, req_ff.character);

   // Execution of the captured item.
   always_comb begin
      exec_status = STS_ACCEPTED;
      exec_walk   = 1'b0;
      exec_read   = 1'b0;
      stage_write = 1'b0;
      len_inc     = staged_len_ff;
      // The length stops one past the maximum so that over-long sequences mismatch.
      if (32'(staged_len_ff) <= 32'(MAX_SITES)) begin
         len_inc = staged_len_ff + LEN_W'(1);
      end
      unique case (kind_type'(req_ff.kind))
         KIND_ADD: begin
            stage_write = 32'(staged_len_ff) < 32'(MAX_SITES);
            if (req_ff.is_last) begin
               if (saturated) begin
                  exec_status = STS_SATURATED;
               end else if (32'(len_inc) != 32'(eff_sites)) begin
                  exec_status = STS_LEN_MISMATCH;
               end else begin
                  exec_status = STS_COMMITTED;
                  exec_walk   = 1'b1;
               end
            end
         end
         KIND_READ_INDEX, KIND_READ_CHAR: begin
            exec_read = 1'b1;
         end
         KIND_NOP: begin
         end
      endcase
   end

   // Count reads.
   always_comb begin
      q_ix = (kind_type'(req_ff.kind) == KIND_READ_INDEX) ? req_ff.set_index : char_ix;
      priority if (32'(req_ff.site) >= 32'(eff_sites) || 32'(req_ff.site) >= 32'(MAX_SITES)) begin
         q_status = STS_BAD_SITE;
      end else if (32'(q_ix) >= 32'(eff_size)) begin
         q_status = STS_BAD_CHAR;
      end else begin
         q_status = STS_ACCEPTED;
      end
      q_addr = ADDR_W'(32'(req_ff.site) * 32'(MAX_CHARS) + 32'(q_ix));
   end

   // Commit walk: staged index read, count read, then increment write, each in the cycle after the one before.
   assign s1_hit  = p1_ff && (32'(s1_ix_ff) < 32'(MAX_CHARS));
   assign s1_addr = ADDR_W'(32'(s1_site_ff) * 32'(MAX_CHARS) + 32'(s1_ix_ff));
   assign rd_addr = p1_ff ? s1_addr : q_addr;

   always_comb begin
      mem_we    = cmd.clear_en || p2_ff;
      mem_waddr = cmd.clear_en ? clear_ptr_ff : s2_addr_ff;
      mem_wdata = cmd.clear_en ? '0 : rdata_ff + COUNT_WIDTH'(1);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= count_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.exec_en && stage_write) begin
         staged_mem[staged_len_ff[SITE_ADDR_W-1:0]] <= char_ix;
      end
      s1_ix_ff <= staged_mem[walk_ptr_ff];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         char_set_ff   <= '0;
         set_size_ff   <= '0;
         site_count_ff <= SITE_COUNT_W'(1024);
         staged_len_ff <= '0;
         total_ff      <= '0;
         clear_ptr_ff  <= '0;
         walk_ptr_ff   <= '0;
         p1_ff         <= 1'b0;
         p2_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index_type'(csr_index))
               CSR_CHAR_SET:   char_set_ff   <= csr_data;
               CSR_SET_SIZE:   set_size_ff   <= csr_data[SET_SIZE_W-1:0];
               CSR_SITE_COUNT: site_count_ff <= csr_data[SITE_COUNT_W-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.clear_en) begin
            clear_ptr_ff <= clear_ptr_ff + ADDR_W'(1);
         end
         if (cmd.exec_en && kind_type'(req_ff.kind) == KIND_ADD) begin
            staged_len_ff <= req_ff.is_last ? '0 : len_inc;
         end
         if (cmd.exec_en) begin
            walk_ptr_ff <= '0;
         end else if (cmd.walk_issue) begin
            walk_ptr_ff <= walk_ptr_ff + SITE_ADDR_W'(1);
         end
         p1_ff <= cmd.walk_issue;
         p2_ff <= s1_hit;
         if (cmd.finish) begin
            total_ff <= total_ff + COUNT_WIDTH'(1);
         end
         rsp_valid_ff <= cmd.exec_respond || cmd.finish || cmd.read_respond;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.exec_en) begin
         q_status_ff <= q_status;
      end
      s1_site_ff <= walk_ptr_ff;
      s2_addr_ff <= s1_addr;
      priority if (cmd.exec_respond) begin
         rsp_ff.status          <= exec_status;
         rsp_ff.count           <= '0;
         rsp_ff.sequences_added <= RSP_SEQ_W'(total_ff);
      end else if (cmd.finish) begin
         rsp_ff.status          <= STS_COMMITTED;
         rsp_ff.count           <= '0;
         rsp_ff.sequences_added <= RSP_SEQ_W'(total_ff + COUNT_WIDTH'(1));
      end else if (cmd.read_respond) begin
         rsp_ff.status          <= q_status_ff;
         rsp_ff.count           <= (q_status_ff == STS_ACCEPTED) ? RSP_COUNT_W'(rdata_ff) : '0;
         rsp_ff.sequences_added <= RSP_SEQ_W'(total_ff);
      end else begin
      end
   end

   always_comb begin
      sts.clear_last = (32'(clear_ptr_ff) == 32'(MEM_DEPTH - 1));
      sts.exec_read  = exec_read;
      sts.exec_walk  = exec_walk;
      sts.walk_last  = (32'(walk_ptr_ff) + 32'd1 == 32'(eff_sites));
      sts.pipe_empty = !p1_ff && !p2_ff;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   `PSCM_ASSERT(a_strobe_single, rsp_valid_ff |=> !rsp_valid_ff, "result strobe lasted more than one cycle")
   `PSCM_ASSERT(a_count_on_read_only, (rsp_valid_ff && rsp_ff.status != STS_ACCEPTED) |-> (rsp_ff.count == '0), "nonzero count with a non-read status")
   `PSCM_ASSERT(a_no_write_clash, p2_ff |-> !cmd.clear_en, "commit write collided with the clearing pass")

endmodule

>>> design/per_site_character_count_matrix_unit.sv
`timescale 1ns / 1ps
// Per-site character count matrix: counts set characters per site over committed sequences.
// Top level; depends on pscm_pkg, pscm_ctrl and pscm_datapath.
//
// After reset the unit holds busy high while it zeroes the count memory one entry per cycle. An
// item is taken when start is high and busy is low; every item gives one result, shown for a
// single cycle with rsp_strobe, and the receiver must take it then since there is no way to hold
// it off. A character that commits a sequence walks its sites one per cycle through a
// read-increment-write pipeline on the single write port of the count memory.
// Configuration writes are taken in every cycle (csr_ready is always high) and belong in idle
// periods only.

module per_site_character_count_matrix_unit
   import pscm_pkg::*;
#(
   parameter int MAX_SITES   = PSCM_MAX_SITES,
   parameter int MAX_CHARS   = PSCM_MAX_CHARS,
   parameter int COUNT_WIDTH = PSCM_COUNT_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_strobe,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   ctl_cmd_type   cmd;
   dp_status_type sts;

   assign csr_ready = 1'b1;

   pscm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   pscm_datapath #(
      .MAX_SITES   (MAX_SITES),
      .MAX_CHARS   (MAX_CHARS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

endmodule
